// ===== rtl/sce_pkg.sv =====
// ----------------------------------------------------------------------------
// sce_pkg
// Shared types, constants and constant tables of the stereo compressor/expander.
// ----------------------------------------------------------------------------
package sce_pkg;

  localparam int SAMPLE_WIDTH_DEF      = 24;
  localparam int LOG_TABLE_ENTRIES_DEF = 256;

  localparam int DB_PER_LOG2  = 394566;
  localparam int LOG2_PER_DB  = 10885;
  localparam int DB_LIMIT_Q8  = 40960;
  localparam int DB_LIMIT_Q16 = 10485760;

  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATK_SMOOTH     = 3'd0,
    REG_REL_SMOOTH     = 3'd1,
    REG_COMP_SLOPE     = 3'd2,
    REG_COMP_THRESHOLD = 3'd3,
    REG_EXP_SLOPE      = 3'd4,
    REG_EXP_THRESHOLD  = 3'd5,
    REG_MAKEUP_GAIN    = 3'd6,
    REG_LINK_MODE      = 3'd7
  } cfg_idx_t;

  localparam logic [1:0] LINK_NONE = 2'd0;
  localparam logic [1:0] LINK_AVG  = 2'd1;
  localparam logic [1:0] LINK_MAX  = 2'd2;

  typedef struct packed {
    logic [15:0]        atk_smooth;
    logic [15:0]        rel_smooth;
    logic signed [15:0] comp_slope;
    logic signed [16:0] comp_threshold;
    logic signed [15:0] exp_slope;
    logic signed [16:0] exp_threshold;
    logic [15:0]        makeup_gain;
    logic [1:0]         link_mode;
  } cfg_t;

  // Q30 roots 2^(-2^-k), k = 1..16, by repeated integer square roots
  typedef logic [15:0][30:0] root_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    for (int j = 0; j < 32; j++) begin
      b = 64'h1 << (62 - 2 * j);
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic root_tab_t build_roots();
    root_tab_t   t;
    logic [63:0] r;
    r = 64'h1 << 29;
    for (int i = 0; i < 16; i++) begin
      r = isqrt64(r << 30);
      t[i] = r[30:0];
    end
    return t;
  endfunction

  localparam root_tab_t ROOT_TAB = build_roots();

endpackage

// ===== rtl/stereo_compressor_expander.sv =====
// ----------------------------------------------------------------------------
// stereo_compressor_expander
// Stereo log-domain compressor/expander with peak detector and stereo link.
// ----------------------------------------------------------------------------
//  channel  ports                                   moves
//  in       in_valid/in_ready, in_*_sample          one stereo sample pair
//  out      out_valid/out_ready, out_*              processed pair, reductions
//  cfg      cfg_valid/cfg_ready, cfg_index/data     one register write
//
// out_valid rises once the sequencer has done, per channel, a leading-one
// search and 16 squarings for the log (both skipped for a zero sample), the
// smoothing products, and root products for the gain, all products through
// the shared multiplier. The next item is taken in the cycle after the
// result moves to the output register.
// Reset (synchronous) clears detector levels and restores register defaults.
// A result waiting on out_ready holds the sequencer at its end; a new item is
// taken as soon as the sequencer is idle. cfg_ready is always high.
// ----------------------------------------------------------------------------
module stereo_compressor_expander #(
  parameter int SAMPLE_WIDTH      = sce_pkg::SAMPLE_WIDTH_DEF,
  parameter int LOG_TABLE_ENTRIES = sce_pkg::LOG_TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [SAMPLE_WIDTH-1:0]          in_left_sample,
  input  logic [SAMPLE_WIDTH-1:0]          in_right_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [SAMPLE_WIDTH-1:0]          out_left_out,
  output logic [SAMPLE_WIDTH-1:0]          out_right_out,
  output logic [15:0]                      out_left_reduction,
  output logic [15:0]                      out_right_reduction,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sce_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sce_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sce_pkg::*;

  cfg_t                    cfg_r;
  logic                    out_valid_r;
  logic [SAMPLE_WIDTH-1:0] left_r, right_r;
  logic [15:0]             lred_r, rred_r;

  logic                    busy, res_valid, res_ready;
  logic [SAMPLE_WIDTH-1:0] res_l, res_r;
  logic [15:0]             red_l, red_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy;
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.atk_smooth     <= 16'd65000;
      cfg_r.rel_smooth     <= 16'd65400;
      cfg_r.comp_slope     <= '0;
      cfg_r.comp_threshold <= '0;
      cfg_r.exp_slope      <= '0;
      cfg_r.exp_threshold  <= -17'sd15360;
      cfg_r.makeup_gain    <= 16'd1024;
      cfg_r.link_mode      <= LINK_NONE;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        REG_ATK_SMOOTH:     cfg_r.atk_smooth     <= cfg_data[15:0];
        REG_REL_SMOOTH:     cfg_r.rel_smooth     <= cfg_data[15:0];
        REG_COMP_SLOPE:     cfg_r.comp_slope     <= cfg_data[15:0];
        REG_COMP_THRESHOLD: cfg_r.comp_threshold <= cfg_data;
        REG_EXP_SLOPE:      cfg_r.exp_slope      <= cfg_data[15:0];
        REG_EXP_THRESHOLD:  cfg_r.exp_threshold  <= cfg_data;
        REG_MAKEUP_GAIN:    cfg_r.makeup_gain    <= cfg_data[15:0];
        REG_LINK_MODE:      cfg_r.link_mode      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      left_r  <= res_l;
      right_r <= res_r;
      lred_r  <= red_l;
      rred_r  <= red_r;
    end
  end

  sce_core #(
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .start    (in_valid && in_ready),
    .xl       (in_left_sample),
    .xr       (in_right_sample),
    .busy     (busy),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_l    (res_l),
    .res_r    (res_r),
    .red_l    (red_l),
    .red_r    (red_r)
  );

  assign out_valid           = out_valid_r;
  assign out_left_out        = left_r;
  assign out_right_out       = right_r;
  assign out_left_reduction  = lred_r;
  assign out_right_reduction = rred_r;

endmodule

// ===== rtl/sce_mul.sv =====
// ----------------------------------------------------------------------------
// sce_mul
// Shared signed 33x33 multiplier with registered product.
// ----------------------------------------------------------------------------
module sce_mul (
  input  logic               clk,
  input  logic signed [32:0] mul_a,
  input  logic signed [32:0] mul_b,
  output logic signed [65:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

// ===== rtl/sce_core.sv =====
// ----------------------------------------------------------------------------
// sce_core
// Sequencer and datapath: level, gain computer, link, smoothing and gain,
// all multiplications through one shared multiplier.
// ----------------------------------------------------------------------------
module sce_core #(
  parameter int SAMPLE_WIDTH      = sce_pkg::SAMPLE_WIDTH_DEF,
  parameter int LOG_TABLE_ENTRIES = sce_pkg::LOG_TABLE_ENTRIES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sce_pkg::cfg_t           cfg,
  input  logic                    start,
  input  logic [SAMPLE_WIDTH-1:0] xl,
  input  logic [SAMPLE_WIDTH-1:0] xr,
  output logic                    busy,
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic [SAMPLE_WIDTH-1:0] res_l,
  output logic [SAMPLE_WIDTH-1:0] res_r,
  output logic [15:0]             red_l,
  output logic [15:0]             red_r
);
  import sce_pkg::*;

  localparam int SW  = SAMPLE_WIDTH;
  localparam int L   = $clog2(LOG_TABLE_ENTRIES);
  localparam int SCW = $clog2(SW);
  localparam logic [39:0] SAT_HI = (40'd1 << (SW - 1)) - 40'd1;
  localparam logic [39:0] SAT_LO = 40'd1 << (SW - 1);

  typedef enum logic [4:0] {
    IDLE, MAG, NORM, SQ_ISS, SQ_USE, ATT_ISS, ATT_USE, GC1, GC2, GC3, LINK,
    REL1, REL2, REL3, ATK1, ATK2, ATK3, GN1, GN2, PW, PW_USE, SHIFT,
    OM1, OM2, OM3, OM4, DONE
  } state_t;

  state_t             state_r;
  logic               ch_r;
  logic [SW-1:0]      x_r [2];
  logic [SW-1:0]      norm_r;
  logic [SCW-1:0]     s_r;
  logic [30:0]        m_r;
  logic [15:0]        lt_r;
  logic [3:0]         cnt_r;
  logic signed [16:0] lv_r;
  logic signed [23:0] cterm_r;
  logic [31:0]        g_r [2];
  logic signed [65:0] acc_r;
  logic [23:0]        y1_r;
  logic [23:0]        rel_r [2];
  logic [23:0]        att_r [2];
  logic [23:0]        y_r [2];
  logic [4:0]         n_r;
  logic [15:0]        f_r;
  logic [30:0]        p_r;
  logic [4:0]         k_r;
  logic [47:0]        v_r;
  logic [SW-1:0]      o_r [2];

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;

  logic [SW-1:0]      mag_c;
  logic [SCW+15:0]    a_c;
  logic [31:0]        sq_c;
  logic signed [65:0] sum_c;
  logic [23:0]        att_c;
  logic signed [23:0] eterm_c, mn_c;
  logic [31:0]        red_c;
  logic [32:0]        gsum_c;
  logic [31:0]        b_c, y1w_c;
  logic [47:0]        v_c;
  logic [39:0]        w_c;
  logic [SW-1:0]      o_c;

  sce_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod_r(prod_r)
  );

  always_comb begin
    mag_c   = x_r[ch_r][SW-1] ? SW'(-x_r[ch_r]) : x_r[ch_r];
    // leading one at the top bit: level at or above full scale, no attenuation
    a_c     = (s_r == '0) ? '0 : ({s_r, 16'h0} - (SCW + 16)'(lt_r));
    sq_c    = prod_r[61:30];
    eterm_c = prod_r[33:10];
    mn_c    = (cterm_r < eterm_c) ? cterm_r : eterm_c;
    red_c   = (mn_c < 0) ? (32'(unsigned'(-mn_c)) << 8) : 32'h0;
    gsum_c  = 33'(g_r[0]) + 33'(g_r[1]);
    v_c     = 48'(prod_r + 66'sd8192 >>> 14);
    // shared rounding adder; its constant and addend follow the state
    sum_c   = prod_r;
    case (state_r)
      ATT_USE: sum_c = prod_r + 66'sd8388608;
      REL3, ATK3: sum_c = acc_r + prod_r + 66'sd32768;
      GN2:     sum_c = prod_r + 66'sd32768;
      PW_USE:  sum_c = prod_r + 66'sd536870912;
      OM4:     sum_c = acc_r + (prod_r <<< 24) + 66'sd33554432;
      default: sum_c = prod_r;
    endcase
    att_c = sum_c[47:24];
    if (att_c > 24'(DB_LIMIT_Q8)) att_c = 24'(DB_LIMIT_Q8);
    b_c   = sum_c[47:16];
    y1w_c = (g_r[ch_r] > b_c) ? g_r[ch_r] : b_c;
    w_c   = sum_c[65:26];
    if (x_r[ch_r][SW-1]) begin
      o_c = (w_c >= SAT_LO) ? SAT_LO[SW-1:0] : SW'(-w_c[SW-1:0]);
    end else begin
      o_c = (w_c > SAT_HI) ? SAT_HI[SW-1:0] : w_c[SW-1:0];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      SQ_ISS: begin
        mul_a = 33'(m_r);
        mul_b = 33'(m_r);
      end
      ATT_ISS: begin
        mul_a = 33'(a_c);
        mul_b = 33'(DB_PER_LOG2);
      end
      GC1: begin
        mul_a = 33'(cfg.comp_slope);
        mul_b = 33'(cfg.comp_threshold) - 33'(lv_r);
      end
      GC2: begin
        mul_a = 33'(cfg.exp_slope);
        mul_b = 33'(cfg.exp_threshold) - 33'(lv_r);
      end
      REL1: begin
        mul_a = 33'(cfg.rel_smooth);
        mul_b = 33'(rel_r[ch_r]);
      end
      REL2: begin
        mul_a = 33'(17'h10000 - 17'(cfg.rel_smooth));
        mul_b = 33'(g_r[ch_r]);
      end
      ATK1: begin
        mul_a = 33'(cfg.atk_smooth);
        mul_b = 33'(att_r[ch_r]);
      end
      ATK2: begin
        mul_a = 33'(17'h10000 - 17'(cfg.atk_smooth));
        mul_b = 33'(y1_r);
      end
      GN1: begin
        mul_a = 33'(y_r[ch_r]);
        mul_b = 33'(LOG2_PER_DB);
      end
      PW: begin
        mul_a = 33'(p_r);
        mul_b = 33'(ROOT_TAB[k_r[3:0]]);
      end
      OM1: begin
        mul_a = 33'(mag_c);
        mul_b = 33'(p_r);
      end
      OM2: begin
        mul_a = 33'(v_c[23:0]);
        mul_b = 33'(cfg.makeup_gain);
      end
      OM3: begin
        mul_a = 33'(v_r[47:24]);
        mul_b = 33'(cfg.makeup_gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= IDLE;
      ch_r     <= 1'b0;
      rel_r[0] <= '0;
      rel_r[1] <= '0;
      att_r[0] <= '0;
      att_r[1] <= '0;
    end else begin
      case (state_r)
        IDLE: begin
          if (start) begin
            x_r[0]  <= xl;
            x_r[1]  <= xr;
            ch_r    <= 1'b0;
            state_r <= MAG;
          end
        end
        MAG: begin
          norm_r <= mag_c;
          s_r    <= '0;
          if (mag_c == '0) begin
            lv_r    <= -17'(DB_LIMIT_Q8);
            state_r <= GC1;
          end else begin
            state_r <= NORM;
          end
        end
        NORM: begin
          if (norm_r[SW-1]) begin
            m_r     <= {1'b1, 30'h0} | (31'(norm_r[SW-2 -: L]) << (30 - L));
            lt_r    <= '0;
            cnt_r   <= '0;
            state_r <= SQ_ISS;
          end else begin
            norm_r <= norm_r << 1;
            s_r    <= s_r + 1'b1;
          end
        end
        SQ_ISS: state_r <= SQ_USE;
        SQ_USE: begin
          lt_r  <= {lt_r[14:0], sq_c[31]};
          m_r   <= sq_c[31] ? sq_c[31:1] : sq_c[30:0];
          cnt_r <= cnt_r + 1'b1;
          state_r <= (cnt_r == 4'd15) ? ATT_ISS : SQ_ISS;
        end
        ATT_ISS: state_r <= ATT_USE;
        ATT_USE: begin
          lv_r    <= -17'(att_c);
          state_r <= GC1;
        end
        GC1: state_r <= GC2;
        GC2: begin
          cterm_r <= prod_r[33:10];
          state_r <= GC3;
        end
        GC3: begin
          g_r[ch_r] <= red_c;
          if (!ch_r) begin
            ch_r    <= 1'b1;
            state_r <= MAG;
          end else begin
            state_r <= LINK;
          end
        end
        LINK: begin
          if (cfg.link_mode == LINK_AVG) begin
            g_r[0] <= gsum_c[32:1];
            g_r[1] <= gsum_c[32:1];
          end else if (cfg.link_mode != LINK_NONE) begin
            g_r[0] <= (g_r[1] > g_r[0]) ? g_r[1] : g_r[0];
            g_r[1] <= (g_r[1] > g_r[0]) ? g_r[1] : g_r[0];
          end
          ch_r    <= 1'b0;
          state_r <= REL1;
        end
        REL1: state_r <= REL2;
        REL2: begin
          acc_r   <= prod_r;
          state_r <= REL3;
        end
        REL3: begin
          y1_r <= (y1w_c > 32'(DB_LIMIT_Q16)) ? 24'(DB_LIMIT_Q16) : y1w_c[23:0];
          state_r <= ATK1;
        end
        ATK1: state_r <= ATK2;
        ATK2: begin
          acc_r   <= prod_r;
          state_r <= ATK3;
        end
        ATK3: begin
          rel_r[ch_r] <= y1_r;
          att_r[ch_r] <= (b_c > 32'(DB_LIMIT_Q16)) ? 24'(DB_LIMIT_Q16) : b_c[23:0];
          y_r[ch_r]   <= (b_c > 32'(DB_LIMIT_Q16)) ? 24'(DB_LIMIT_Q16) : b_c[23:0];
          ch_r        <= ~ch_r;
          state_r     <= ch_r ? GN1 : REL1;
        end
        GN1: state_r <= GN2;
        GN2: begin
          n_r     <= sum_c[36:32];
          f_r     <= sum_c[31:16];
          p_r     <= {1'b1, 30'h0};
          k_r     <= '0;
          state_r <= PW;
        end
        PW: begin
          // one root factor per set bit of the fraction, MSB first
          if (k_r[4]) begin
            state_r <= SHIFT;
          end else if (f_r[4'd15 - k_r[3:0]]) begin
            state_r <= PW_USE;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        PW_USE: begin
          p_r     <= sum_c[60:30];
          k_r     <= k_r + 1'b1;
          state_r <= PW;
        end
        SHIFT: begin
          p_r     <= (n_r == 5'd31) ? 31'h0 : (p_r >> n_r);
          state_r <= OM1;
        end
        OM1: state_r <= OM2;
        OM2: begin
          v_r     <= v_c;
          state_r <= OM3;
        end
        OM3: begin
          acc_r   <= prod_r;
          state_r <= OM4;
        end
        OM4: begin
          o_r[ch_r] <= o_c;
          ch_r      <= ~ch_r;
          state_r   <= ch_r ? DONE : GN1;
        end
        DONE: begin
          if (res_ready) state_r <= IDLE;
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  assign busy      = (state_r != IDLE);
  assign res_valid = (state_r == DONE);
  assign res_l     = o_r[0];
  assign res_r     = o_r[1];
  assign red_l     = 16'((25'(y_r[0]) + 25'd128) >> 8);
  assign red_r     = 16'((25'(y_r[1]) + 25'd128) >> 8);

endmodule
